/* hdl/mcbf_pkg.sv */
package mcbf_pkg;

  localparam int CH_W     = 3;
  localparam int LEVEL_W  = 8;
  localparam int NOW_W    = 32;
  localparam int CFG_W    = 16;
  localparam int CIDX_W   = 3;
  localparam int NCH_W    = 4;
  localparam int FRAC_W   = 16;
  localparam int STEP_W   = LEVEL_W + FRAC_W;
  localparam int MODE_W   = 2;

  localparam int MAX_CHANNELS_DEF = 8;
  // channel field reaches this many entries at most
  localparam int CH_SPAN = 1 << CH_W;

  localparam logic [STEP_W-1:0] TOTAL_CAP = {{LEVEL_W{1'b1}}, {FRAC_W{1'b0}}};

  localparam logic [CFG_W-1:0]   RUN_TIME_RST = 16'd1000;
  localparam logic [CFG_W-1:0]   INTERVAL_RST = 16'd20;
  localparam logic [LEVEL_W-1:0] MIN_RST      = 8'd0;
  localparam logic               FADE_IN_RST  = 1'b1;
  localparam logic [NCH_W-1:0]   NCH_RST      = 4'd8;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_RUN_TIME = 3'd0,
    CFG_INTERVAL = 3'd1,
    CFG_MIN      = 3'd2,
    CFG_FADE_IN  = 3'd3,
    CFG_NCH      = 3'd4
  } cfg_idx_t;

  // brightness of one channel for the current running total
  function automatic logic [LEVEL_W-1:0] fade_level(
    input logic [LEVEL_W-1:0] orig,
    input logic [LEVEL_W-1:0] mn,
    input logic [STEP_W-1:0]  total,
    input logic               fade_in
  );
    logic [LEVEL_W:0]   up;
    logic [LEVEL_W+1:0] dn;
    logic [LEVEL_W-1:0] res;
    up = {1'b0, mn} + {1'b0, total[STEP_W-1:FRAC_W]};
    // floor(orig - total): borrow one more when the fraction is nonzero
    dn = {2'b00, orig} - {2'b00, total[STEP_W-1:FRAC_W]}
         - (LEVEL_W+2)'(|total[FRAC_W-1:0]);
    if (fade_in) begin
      res = (up > {1'b0, orig}) ? orig : up[LEVEL_W-1:0];
    end else if (dn[LEVEL_W+1] || (dn[LEVEL_W-1:0] < mn)) begin
      res = mn;
    end else begin
      res = dn[LEVEL_W-1:0];
    end
    return res;
  endfunction

endpackage

/* hdl/mcbf_chan_store.sv */
module mcbf_chan_store #(
  parameter int DEPTH = mcbf_pkg::MAX_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [mcbf_pkg::CH_W-1:0]    wr_ch,
  input  logic [mcbf_pkg::LEVEL_W-1:0] wr_level,
  input  logic                         wr_present,
  input  logic [mcbf_pkg::NCH_W-1:0]   rd_ch,
  input  logic [mcbf_pkg::NCH_W-1:0]   limit,
  output logic [mcbf_pkg::LEVEL_W-1:0] rd_level,
  output logic                         rd_present,
  output logic                         rd_more
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [mcbf_pkg::LEVEL_W-1:0] orig_r [DEPTH];
  logic [DEPTH-1:0]             pres_r;
  logic [DEPTH-1:0]             pres_nxt;
  logic                         in_range;
  logic                         wr_ok;

  assign wr_ok    = wr_en && ({1'b0, wr_ch} < (mcbf_pkg::CH_W+1)'(DEPTH));
  assign in_range = rd_ch < mcbf_pkg::NCH_W'(DEPTH);

  always_comb begin
    pres_nxt = pres_r;
    if (wr_ok) begin
      pres_nxt[wr_ch[IDX_W-1:0]] = wr_present;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r <= '0;
    end else begin
      pres_r <= pres_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      orig_r[wr_ch[IDX_W-1:0]] <= wr_level;
    end
  end

  assign rd_level   = in_range ? orig_r[rd_ch[IDX_W-1:0]] : '0;
  assign rd_present = in_range && pres_r[rd_ch[IDX_W-1:0]];

  // any present channel after the one being read, still inside the limit
  always_comb begin
    rd_more = 1'b0;
    for (int j = 0; j < DEPTH; j++) begin
      if (pres_r[j] && (mcbf_pkg::NCH_W'(j) > rd_ch) && (mcbf_pkg::NCH_W'(j) < limit)) begin
        rd_more = 1'b1;
      end
    end
  end

endmodule

/* hdl/mcbf_div.sv */
module mcbf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mcbf_pkg::STEP_W-1:0] dividend,
  input  logic [mcbf_pkg::CFG_W-1:0]  divisor,
  output logic                        done,
  output logic [mcbf_pkg::STEP_W-1:0] quotient
);

  localparam int DVD_W = mcbf_pkg::STEP_W;
  localparam int DEN_W = mcbf_pkg::CFG_W;
  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor};
  assign done   = busy_r && (cnt_r == LAST);
  assign quotient = {q_r[DVD_W-2:0], ge};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      q_nxt    = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, divisor}) : rem_sh[DEN_W-1:0];
      q_nxt   = quotient;
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

endmodule

/* hdl/mcbf_mul.sv */
module mcbf_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mcbf_pkg::STEP_W-1:0] mcand,
  input  logic [mcbf_pkg::NOW_W-1:0]  mplier,
  output logic                        done,
  output logic [mcbf_pkg::STEP_W-1:0] prod_lo,
  output logic                        prod_ovf
);

  localparam int A_W   = mcbf_pkg::STEP_W;
  localparam int B_W   = mcbf_pkg::NOW_W;
  localparam int CNT_W = $clog2(B_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(B_W - 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [B_W-1:0]   b_r, b_nxt;
  logic [A_W-1:0]   hi_r, hi_nxt;
  logic [B_W-1:0]   lo_r, lo_nxt;
  logic [A_W:0]     add;

  // shift-add, multiplier LSB first, product shifts right into lo
  assign add = {1'b0, hi_r} + (b_r[0] ? {1'b0, mcand} : '0);
  assign done     = busy_r && (cnt_r == LAST);
  assign prod_lo  = lo_nxt[A_W-1:0];
  assign prod_ovf = (|hi_nxt) || (|lo_nxt[B_W-1:A_W]);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    b_nxt    = b_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      b_nxt    = mplier;
      hi_nxt   = '0;
      lo_nxt   = '0;
    end else if (busy_r) begin
      hi_nxt  = add[A_W:1];
      lo_nxt  = {add[0], lo_r[B_W-1:1]};
      b_nxt   = {1'b0, b_r[B_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r  <= b_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

endmodule

/* hdl/multi_channel_brightness_fader.sv */
// Load items: no beats out. Restart mid-fade and the tick that ends the fade:
// a walk over the channels in use that sends the stored originals out. Fade update
// tick: a check, the bit-serial multiplier, then a walk over the channels in use;
// the first tick adds a max scan and the bit-serial divider. One item at a time;
// the next is taken once the last beat sits in the output register. Synchronous
// active-low reset clears control, flags, presence and configuration; stored levels
// stay undefined until loaded.
module multi_channel_brightness_fader #(
  parameter int MAX_CHANNELS = mcbf_pkg::MAX_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mcbf_pkg::MODE_W-1:0]   in_mode,
  input  logic [mcbf_pkg::CH_W-1:0]     in_channel,
  input  logic [mcbf_pkg::LEVEL_W-1:0]  in_level,
  input  logic                          in_present,
  input  logic [mcbf_pkg::NOW_W-1:0]    in_now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mcbf_pkg::CH_W-1:0]     out_channel,
  output logic [mcbf_pkg::LEVEL_W-1:0]  out_level,
  output logic                          out_last,
  output logic                          out_fade_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mcbf_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [mcbf_pkg::CFG_W-1:0]    cfg_data
);

  localparam int STORE_DEPTH = (MAX_CHANNELS < mcbf_pkg::CH_SPAN) ? MAX_CHANNELS
                                                                  : mcbf_pkg::CH_SPAN;
  localparam int NCH_W  = mcbf_pkg::NCH_W;
  localparam int LVL_W  = mcbf_pkg::LEVEL_W;
  localparam int STEP_W = mcbf_pkg::STEP_W;
  localparam int NOW_W  = mcbf_pkg::NOW_W;
  localparam int CFG_W  = mcbf_pkg::CFG_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] run_time_r, run_time_nxt;
  logic [CFG_W-1:0] interval_r, interval_nxt;
  logic [LVL_W-1:0] min_r, min_nxt;
  logic             fade_in_r, fade_in_nxt;
  logic [NCH_W-1:0] nch_r, nch_nxt;

  logic              started_r, started_nxt;
  logic              done_r, done_nxt;
  logic [NOW_W-1:0]  start_time_r, start_time_nxt;
  logic [NOW_W-1:0]  prev_r, prev_nxt;
  logic [NOW_W-1:0]  now_r, now_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [STEP_W-1:0] total_r, total_nxt;
  logic [NCH_W-1:0]  cnt_r, cnt_nxt;
  logic [LVL_W-1:0]  mx_r, mx_nxt;
  logic              emit_orig_r, emit_orig_nxt;
  logic              done_bit_r, done_bit_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [mcbf_pkg::CH_W-1:0]    out_channel_r, out_channel_nxt;
  logic [LVL_W-1:0]             out_level_r, out_level_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_fade_done_r, out_fade_done_nxt;

  logic              in_acc;
  logic              load_en;
  logic [NCH_W-1:0]  limit;
  logic [LVL_W-1:0]  rd_level;
  logic              rd_present;
  logic              rd_more;
  logic              out_free;
  logic              div_start, div_done;
  logic [STEP_W-1:0] div_q;
  logic              mul_start, mul_done;
  logic [STEP_W-1:0] mul_lo;
  logic              mul_ovf;
  logic [NOW_W-1:0]  since_start;
  logic [NOW_W-1:0]  elapsed;
  logic [STEP_W:0]   acc_sum;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_en   = in_acc && (in_mode == mcbf_pkg::MODE_LOAD);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign limit     = (nch_r > NCH_W'(STORE_DEPTH)) ? NCH_W'(STORE_DEPTH) : nch_r;

  assign since_start = now_r - start_time_r;
  assign elapsed     = now_r - prev_r;
  assign acc_sum     = {1'b0, total_r} + {1'b0, mul_lo};

  mcbf_chan_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (load_en),
    .wr_ch      (in_channel),
    .wr_level   (in_level),
    .wr_present (in_present),
    .rd_ch      (cnt_r),
    .limit      (limit),
    .rd_level   (rd_level),
    .rd_present (rd_present),
    .rd_more    (rd_more)
  );

  mcbf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({LVL_W'(mx_r - min_r), {mcbf_pkg::FRAC_W{1'b0}}}),
    .divisor  (run_time_r),
    .done     (div_done),
    .quotient (div_q)
  );

  mcbf_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_start),
    .mcand    (step_r),
    .mplier   (elapsed),
    .done     (mul_done),
    .prod_lo  (mul_lo),
    .prod_ovf (mul_ovf)
  );

  always_comb begin
    run_time_nxt = run_time_r;
    interval_nxt = interval_r;
    min_nxt      = min_r;
    fade_in_nxt  = fade_in_r;
    nch_nxt      = nch_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mcbf_pkg::CFG_RUN_TIME: run_time_nxt = cfg_data;
        mcbf_pkg::CFG_INTERVAL: interval_nxt = cfg_data;
        mcbf_pkg::CFG_MIN:      min_nxt      = cfg_data[LVL_W-1:0];
        mcbf_pkg::CFG_FADE_IN:  fade_in_nxt  = cfg_data[0];
        mcbf_pkg::CFG_NCH:      nch_nxt      = cfg_data[NCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt         = state_r;
    started_nxt       = started_r;
    done_nxt          = done_r;
    start_time_nxt    = start_time_r;
    prev_nxt          = prev_r;
    now_nxt           = now_r;
    step_nxt          = step_r;
    total_nxt         = total_r;
    cnt_nxt           = cnt_r;
    mx_nxt            = mx_r;
    emit_orig_nxt     = emit_orig_r;
    done_bit_nxt      = done_bit_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_channel_nxt   = out_channel_r;
    out_level_nxt     = out_level_r;
    out_last_nxt      = out_last_r;
    out_fade_done_nxt = out_fade_done_r;
    div_start         = 1'b0;
    mul_start         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            mcbf_pkg::MODE_TICK: begin
              now_nxt = in_now_ms;
              if (!done_r) begin
                if (started_r) begin
                  state_nxt = ST_CHECK;
                end else begin
                  start_time_nxt = in_now_ms;
                  prev_nxt       = in_now_ms - NOW_W'(interval_r);
                  started_nxt    = 1'b1;
                  if (run_time_r == '0) begin
                    step_nxt  = '0;
                    state_nxt = ST_CHECK;
                  end else begin
                    mx_nxt    = '0;
                    cnt_nxt   = '0;
                    state_nxt = ST_SCAN;
                  end
                end
              end
            end
            mcbf_pkg::MODE_RESTART: begin
              if (started_r && !done_r) begin
                emit_orig_nxt = 1'b1;
                done_bit_nxt  = 1'b0;
                cnt_nxt       = '0;
                state_nxt     = ST_EMIT;
              end
              started_nxt = 1'b0;
              done_nxt    = 1'b0;
              total_nxt   = '0;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (cnt_r >= limit) begin
          if (mx_r > min_r) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            step_nxt  = '0;
            state_nxt = ST_CHECK;
          end
        end else begin
          if (rd_present && (rd_level > mx_r)) begin
            mx_nxt = rd_level;
          end
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          step_nxt  = div_q;
          state_nxt = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (since_start >= NOW_W'(run_time_r)) begin
          done_nxt      = 1'b1;
          emit_orig_nxt = 1'b1;
          done_bit_nxt  = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_EMIT;
        end else if (elapsed < NOW_W'(interval_r)) begin
          state_nxt = ST_IDLE;
        end else begin
          mul_start = 1'b1;
          state_nxt = ST_MUL;
        end
      end

      ST_MUL: begin
        if (mul_done) begin
          // saturate the running total at full scale
          if (mul_ovf || (acc_sum > {1'b0, mcbf_pkg::TOTAL_CAP})) begin
            total_nxt = mcbf_pkg::TOTAL_CAP;
          end else begin
            total_nxt = acc_sum[STEP_W-1:0];
          end
          prev_nxt      = now_r;
          emit_orig_nxt = 1'b0;
          done_bit_nxt  = 1'b0;
          cnt_nxt       = '0;
          state_nxt     = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (cnt_r >= limit) begin
          state_nxt = ST_IDLE;
        end else if (!rd_present) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_channel_nxt   = cnt_r[mcbf_pkg::CH_W-1:0];
          out_level_nxt     = emit_orig_r ? rd_level
                              : mcbf_pkg::fade_level(rd_level, min_r, total_r, fade_in_r);
          out_last_nxt      = !rd_more;
          out_fade_done_nxt = done_bit_r;
          cnt_nxt           = cnt_r + 1'b1;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      run_time_r   <= mcbf_pkg::RUN_TIME_RST;
      interval_r   <= mcbf_pkg::INTERVAL_RST;
      min_r        <= mcbf_pkg::MIN_RST;
      fade_in_r    <= mcbf_pkg::FADE_IN_RST;
      nch_r        <= mcbf_pkg::NCH_RST;
      started_r    <= 1'b0;
      done_r       <= 1'b0;
      start_time_r <= '0;
      prev_r       <= '0;
      step_r       <= '0;
      total_r      <= '0;
      cnt_r        <= '0;
      emit_orig_r  <= 1'b0;
      done_bit_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      run_time_r   <= run_time_nxt;
      interval_r   <= interval_nxt;
      min_r        <= min_nxt;
      fade_in_r    <= fade_in_nxt;
      nch_r        <= nch_nxt;
      started_r    <= started_nxt;
      done_r       <= done_nxt;
      start_time_r <= start_time_nxt;
      prev_r       <= prev_nxt;
      step_r       <= step_nxt;
      total_r      <= total_nxt;
      cnt_r        <= cnt_nxt;
      emit_orig_r  <= emit_orig_nxt;
      done_bit_r   <= done_bit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r           <= now_nxt;
    mx_r            <= mx_nxt;
    out_channel_r   <= out_channel_nxt;
    out_level_r     <= out_level_nxt;
    out_last_r      <= out_last_nxt;
    out_fade_done_r <= out_fade_done_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_channel   = out_channel_r;
  assign out_level     = out_level_r;
  assign out_last      = out_last_r;
  assign out_fade_done = out_fade_done_r;

`ifndef SYNTHESIS
  a_total_capped: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= mcbf_pkg::TOTAL_CAP)
    else $error("running total above full scale");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside its wait state");

  a_mul_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL))
    else $error("multiplier finished outside its wait state");

  a_done_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> started_r)
    else $error("fade marked done without having started");
`endif

endmodule

/* tb/tb_multi_channel_brightness_fader.sv */
`timescale 1ns / 100ps

module tb_multi_channel_brightness_fader;
  import mcbf_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int ITEM_TARGET   = 400;
  localparam int NUM_CH        = MAX_CHANNELS_DEF;

  typedef struct {
    logic [CH_W-1:0]    ch;
    logic [LEVEL_W-1:0] lvl;
    logic               last;
    logic               done;
  } level_beat_t;

  typedef struct {
    mode_t              mode;
    logic [CH_W-1:0]    ch;
    logic [LEVEL_W-1:0] lvl;
    logic               pres;
    logic [NOW_W-1:0]   now;
  } fader_item_t;

  // Tracks stored levels, fade progress and settings; queues the levels due out.
  class fade_tracker;
    bit [CFG_W-1:0]   run_time;
    bit [CFG_W-1:0]   interval;
    bit [LEVEL_W-1:0] min_lvl;
    bit               fade_in;
    bit [NCH_W-1:0]   nch;
    bit [LEVEL_W-1:0] orig [NUM_CH];
    bit               pres [NUM_CH];
    bit               started;
    bit               done;
    bit [NOW_W-1:0]   t_start;
    bit [NOW_W-1:0]   t_prev;
    bit [STEP_W-1:0]  step;
    bit [STEP_W-1:0]  total;
    level_beat_t      due_beats[$];
    int               errors;

    function new();
      run_time = RUN_TIME_RST;
      interval = INTERVAL_RST;
      min_lvl  = MIN_RST;
      fade_in  = FADE_IN_RST;
      nch      = NCH_RST;
      foreach (pres[i]) begin
        pres[i] = 1'b0;
        orig[i] = '0;
      end
      started = 1'b0;
      done    = 1'b0;
      t_start = '0;
      t_prev  = '0;
      step    = '0;
      total   = '0;
      errors  = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, bit [CFG_W-1:0] d);
      case (idx)
        CFG_RUN_TIME: run_time = d;
        CFG_INTERVAL: interval = d;
        CFG_MIN:      min_lvl  = d[LEVEL_W-1:0];
        CFG_FADE_IN:  fade_in  = d[0];
        CFG_NCH:      nch      = d[NCH_W-1:0];
        default: ;
      endcase
    endfunction

    function int live_channels();
      return (nch > NUM_CH) ? NUM_CH : int'(nch);
    endfunction

    function bit [LEVEL_W-1:0] faded_level(int ch);
      bit [31:0] up;
      bit [31:0] oq;
      bit [31:0] mq;
      bit [31:0] vq;
      if (fade_in) begin
        up = min_lvl + total[STEP_W-1:FRAC_W];
        return (up > orig[ch]) ? orig[ch] : up[LEVEL_W-1:0];
      end
      oq = orig[ch];
      oq = oq << FRAC_W;
      mq = min_lvl;
      mq = mq << FRAC_W;
      if (oq < total) return min_lvl;
      vq = oq - total;
      if (vq < mq) return min_lvl;
      return vq[STEP_W-1:FRAC_W];
    endfunction

    function void queue_levels(bit originals, bit done_bit);
      int          last_ch;
      level_beat_t b;
      last_ch = -1;
      for (int i = 0; i < live_channels(); i++)
        if (pres[i]) last_ch = i;
      for (int i = 0; i < live_channels(); i++) begin
        if (pres[i]) begin
          b.ch   = CH_W'(i);
          b.lvl  = originals ? orig[i] : faded_level(i);
          b.last = (i == last_ch);
          b.done = done_bit;
          due_beats.push_back(b);
        end
      end
    endfunction

    function void begin_fade(bit [NOW_W-1:0] now);
      bit [LEVEL_W-1:0] peak;
      bit [47:0]        num;
      t_start = now;
      t_prev  = now - interval;
      started = 1'b1;
      peak    = '0;
      for (int i = 0; i < live_channels(); i++)
        if (pres[i] && orig[i] > peak) peak = orig[i];
      if (run_time != 0 && peak > min_lvl) begin
        num  = 48'(peak - min_lvl) << FRAC_W;
        step = STEP_W'(num / run_time);
      end else begin
        step = '0;
      end
    endfunction

    function void note_item(fader_item_t it);
      bit [NOW_W-1:0] since;
      bit [NOW_W-1:0] elapsed;
      bit [63:0]      sum;
      case (it.mode)
        MODE_LOAD: begin
          orig[it.ch] = it.lvl;
          pres[it.ch] = it.pres;
        end
        MODE_RESTART: begin
          if (started && !done) queue_levels(1'b1, 1'b0);
          started = 1'b0;
          done    = 1'b0;
          total   = '0;
        end
        MODE_TICK: begin
          if (!done) begin
            if (!started) begin_fade(it.now);
            since = it.now - t_start;
            if (since >= run_time) begin
              done = 1'b1;
              queue_levels(1'b1, 1'b1);
            end else begin
              elapsed = it.now - t_prev;
              if (elapsed >= interval) begin
                sum   = 64'(total) + 64'(step) * 64'(elapsed);
                total = (sum > 64'(TOTAL_CAP)) ? TOTAL_CAP : sum[STEP_W-1:0];
                queue_levels(1'b0, 1'b0);
                t_prev = it.now;
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_beat(level_beat_t got);
      level_beat_t want;
      if (due_beats.size() == 0) begin
        errors++;
        $display("%0t beat with none due: expected nothing actual ch %0d level %0d last %0b done %0b",
                 $time, got.ch, got.lvl, got.last, got.done);
        return;
      end
      want = due_beats.pop_front();
      compare_field("out_channel", want.ch, got.ch);
      compare_field("out_level", want.lvl, got.lvl);
      compare_field("out_last", want.last, got.last);
      compare_field("out_fade_done", want.done, got.done);
    endfunction

    function int pending();
      return due_beats.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [MODE_W-1:0]    in_mode;
  logic [CH_W-1:0]      in_channel;
  logic [LEVEL_W-1:0]   in_level;
  logic                 in_present;
  logic [NOW_W-1:0]     in_now_ms;
  logic                 out_valid;
  logic                 out_stall;
  logic [CH_W-1:0]      out_channel;
  logic [LEVEL_W-1:0]   out_level;
  logic                 out_last;
  logic                 out_fade_done;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CIDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  fade_tracker tracker;
  int unsigned items_sent;
  int unsigned burst_left;
  bit          hold_req;
  int          idle_cycles;

  multi_channel_brightness_fader u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_channel    (in_channel),
    .in_level      (in_level),
    .in_present    (in_present),
    .in_now_ms     (in_now_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_channel   (out_channel),
    .out_level     (out_level),
    .out_last      (out_last),
    .out_fade_done (out_fade_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic fader_item_t fader_item(mode_t m, logic [CH_W-1:0] ch,
                                             logic [LEVEL_W-1:0] lvl, logic pres,
                                             logic [NOW_W-1:0] now);
    fader_item_t it;
    it.mode = m;
    it.ch   = ch;
    it.lvl  = lvl;
    it.pres = pres;
    it.now  = now;
    return it;
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return LEVEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [NOW_W-1:0] tick_gap(int unsigned rt, int unsigned iv);
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return $urandom_range(0, iv);
      8: return $urandom_range(0, rt);
      9: return $urandom();
      default: return iv + $urandom_range(0, rt / 8 + 1);
    endcase
  endfunction

  task automatic send_item(fader_item_t it);
    in_valid   <= 1'b1;
    in_mode    <= it.mode;
    in_channel <= it.ch;
    in_level   <= it.lvl;
    in_present <= it.pres;
    in_now_ms  <= it.now;
    do @(posedge clk); while (in_stall);
    tracker.note_item(it);
    if (it.mode != MODE_NONE) items_sent++;
    // keep valid up inside a burst, drop it for the gap after
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 8);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    // a tick with no beats may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(bit [CFG_W-1:0] rt, bit [CFG_W-1:0] iv, bit [LEVEL_W-1:0] mn,
                              bit fi, bit [NCH_W-1:0] nc);
    cfg_idx_t       idx [5];
    bit [CFG_W-1:0] vals [5];
    idx  = '{CFG_RUN_TIME, CFG_INTERVAL, CFG_MIN, CFG_FADE_IN, CFG_NCH};
    vals = '{rt, iv, CFG_W'(mn), CFG_W'(fi), CFG_W'(nc)};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      tracker.write_reg(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic directed_items();
    // reset settings: 1000 ms run, 20 ms interval, fade in from zero, all channels
    send_item(fader_item(MODE_RESTART, 3'd0, 8'd0, 1'b0, '0));
    send_item(fader_item(MODE_NONE, 3'd7, 8'hFF, 1'b1, '1));
    send_item(fader_item(MODE_LOAD, 3'd0, 8'hFF, 1'b1, '0));
    send_item(fader_item(MODE_LOAD, 3'd7, 8'h00, 1'b1, '0));
    send_item(fader_item(MODE_LOAD, 3'd3, 8'd128, 1'b1, '0));
    send_item(fader_item(MODE_LOAD, 3'd5, 8'd77, 1'b0, '0));
    // start just below the wrap of the millisecond counter
    send_item(fader_item(MODE_TICK, 3'd0, 8'd0, 1'b0, 32'hFFFF_FFF0));
    send_item(fader_item(MODE_TICK, 3'd0, 8'd0, 1'b0, 32'hFFFF_FFF5));
    send_item(fader_item(MODE_TICK, 3'd0, 8'd0, 1'b0, 32'h0000_0010));
    send_item(fader_item(MODE_LOAD, 3'd1, 8'd200, 1'b1, '0));
    send_item(fader_item(MODE_TICK, 3'd0, 8'd0, 1'b0, 32'h0000_0100));
    send_item(fader_item(MODE_RESTART, 3'd0, 8'd0, 1'b0, '0));
    send_item(fader_item(MODE_TICK, 3'd0, 8'd0, 1'b0, 32'd0));
    send_item(fader_item(MODE_TICK, 3'd0, 8'd0, 1'b0, 32'd999));
    send_item(fader_item(MODE_TICK, 3'd0, 8'd0, 1'b0, 32'd1000));
    send_item(fader_item(MODE_TICK, 3'd0, 8'd0, 1'b0, 32'd5000));
    drain();
    // zero run time, floor at the highest level, fade out
    write_config('0, '0, 8'hFF, 1'b0, 4'd8);
    send_item(fader_item(MODE_TICK, 3'd0, 8'd0, 1'b0, $urandom()));
    send_item(fader_item(MODE_TICK, 3'd0, 8'd0, 1'b0, $urandom()));
    send_item(fader_item(MODE_RESTART, 3'd0, 8'd0, 1'b0, '0));
    drain();
    write_config('1, '0, 8'hFF, 1'b0, 4'd8);
    send_item(fader_item(MODE_TICK, 3'd0, 8'd0, 1'b0, 32'h8000_0000));
    send_item(fader_item(MODE_TICK, 3'd0, 8'd0, 1'b0, 32'h8000_0000));
    send_item(fader_item(MODE_RESTART, 3'd0, 8'd0, 1'b0, '0));
    drain();
    write_config('1, '1, 8'd0, 1'b1, 4'd1);
    send_item(fader_item(MODE_TICK, 3'd0, 8'd0, 1'b0, '1));
    send_item(fader_item(MODE_RESTART, 3'd0, 8'd0, 1'b0, '0));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(3, 8))
      send_item(fader_item(mode_t'($urandom_range(0, 3)), $urandom_range(0, 7),
                           $urandom_range(0, 255), $urandom_range(0, 1), $urandom()));
  endtask

  task automatic fade_sequence();
    logic [NOW_W-1:0] now;
    int unsigned      rt;
    int unsigned      iv;
    int               ticks;
    int               pick;
    rt = tracker.run_time;
    iv = tracker.interval;
    send_item(fader_item(MODE_RESTART, $urandom_range(0, 7), $urandom_range(0, 255),
                         $urandom_range(0, 1), $urandom()));
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4))
        send_item(fader_item(MODE_LOAD, $urandom_range(0, 7), pick_level(),
                             $urandom_range(0, 3) != 0, $urandom()));
    end else begin
      for (int c = 0; c < NUM_CH; c++)
        send_item(fader_item(MODE_LOAD, CH_W'(c), pick_level(),
                             $urandom_range(0, 3) != 0, $urandom()));
    end
    now   = $urandom();
    ticks = $urandom_range(3, 14);
    for (int k = 0; k < ticks && !tracker.done; k++) begin
      send_item(fader_item(MODE_TICK, $urandom_range(0, 7), $urandom_range(0, 255),
                           $urandom_range(0, 1), now));
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        send_item(fader_item(MODE_LOAD, $urandom_range(0, 7), pick_level(),
                             $urandom_range(0, 3) != 0, $urandom()));
      end else if (pick == 2) begin
        send_item(fader_item(MODE_RESTART, 3'd0, 8'd0, 1'b0, now));
        break;
      end
      now = now + tick_gap(rt, iv);
    end
    // one tick past the end of the fade now and then
    if (tracker.done && $urandom_range(0, 1) == 1)
      send_item(fader_item(MODE_TICK, 3'd0, 8'd0, 1'b0, now));
  endtask

  task automatic random_phase(int p);
    bit [CFG_W-1:0]   rt;
    bit [CFG_W-1:0]   iv;
    bit [LEVEL_W-1:0] mn;
    bit               fi;
    bit [NCH_W-1:0]   nc;
    int               n;
    drain();
    case (p)
      0: begin rt = 16'd200; iv = 16'd10; mn = 8'd0;   fi = 1'b1; nc = 4'd8;  end
      1: begin rt = '1;      iv = '1;     mn = 8'hFF;  fi = 1'b0; nc = 4'd1;  end
      2: begin rt = '0;      iv = '0;     mn = 8'd30;  fi = 1'b0; nc = 4'hF;  end
      3: begin rt = 16'd100; iv = '0;     mn = 8'd0;   fi = 1'b0; nc = 4'd8;  end
      4: begin rt = 16'd50;  iv = 16'd5;  mn = 8'd100; fi = 1'b1; nc = 4'd0;  end
      default: begin
        rt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 400);
        iv = $urandom_range(0, 40);
        mn = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
        fi = $urandom_range(0, 1);
        nc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      end
    endcase
    write_config(rt, iv, mn, fi, nc);
    if (p == 0 || $urandom_range(0, 9) == 0) hold_req = 1'b1;
    n = (nc == 0) ? 2 : $urandom_range(4, 8);
    repeat (n) begin
      if ($urandom_range(0, 6) == 0) noise_burst();
      else fade_sequence();
    end
  endtask

  initial begin : receiver
    int style;
    int len;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        // hold off long enough for the block to back up into its input
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        style = $urandom_range(0, 3);
        len   = $urandom_range(10, 60);
        repeat (len) begin
          case (style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_beat(level_beat_t'{out_channel, out_level, out_last, out_fade_done});
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("multi_channel_brightness_fader: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    tracker     = new();
    items_sent  = 0;
    burst_left  = 0;
    hold_req    = 1'b0;
    idle_cycles = 0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_mode    <= MODE_LOAD;
    in_channel <= '0;
    in_level   <= '0;
    in_present <= 1'b0;
    in_now_ms  <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_RUN_TIME;
    cfg_data   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    p = 0;
    while (items_sent < ITEM_TARGET) begin
      random_phase(p);
      p++;
    end
    drain();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("multi_channel_brightness_fader: match");
    end else begin
      $display("multi_channel_brightness_fader: mismatch");
    end
    $finish;
  end

endmodule
